>>> src/wec_pkg.sv
package wec_pkg;

    // Block sizes
    localparam int FRAME_LENGTH   = 480;
    localparam int HISTORY_LENGTH = 1920;
    localparam int TAP_COUNT      = 480;

    localparam int HAW  = $clog2(HISTORY_LENGTH);
    localparam int HAW1 = HAW + 1;
    localparam int TCW  = $clog2(TAP_COUNT + 1);
    localparam int WAW  = $clog2(TAP_COUNT);

    // Iterative divider sizes
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;
    localparam int DIV_CW = $clog2(DIV_NW);

    // Tap weights: Q16 of 10/(10+j)
    localparam int W_W        = 17;
    localparam int WEIGHT_NUM = 655360;
    localparam int WEIGHT_D0  = 10;
    localparam int WDW        = $clog2(WEIGHT_D0 + TAP_COUNT + 1);

    // Fixed-point constants
    localparam int EPS_Q30    = 107374;
    localparam int GMIN_Q15   = 3277;
    localparam int GSPAN_Q15  = 22938;
    localparam int RATE_Q15   = 9830;
    localparam int CORR_MIN   = 328;
    localparam int SUPP_Y_MIN = 327;
    localparam int SUPP_E_MIN = 1638;
    localparam int SUPP_DIV   = 5;

    // Divide by five as a multiply by ceil(2^18 / 5) and a shift, exact for 17-bit inputs
    localparam int SUPP_RECIP = 52429;
    localparam int SUPP_SHIFT = 18;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_NEAR  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_WF_START,
        ST_WF_WAIT,
        ST_IDLE,
        ST_MAC,
        ST_E_START,
        ST_E_WAIT,
        ST_MUL_EE,
        ST_MUL_XE,
        ST_C_START,
        ST_C_WAIT,
        ST_GAIN_MUL,
        ST_GAIN,
        ST_MUL_EG,
        ST_E2,
        ST_MUL_ERR,
        ST_MUL_RATE,
        ST_D_START,
        ST_D_WAIT,
        ST_E3,
        ST_Y,
        ST_S_START,
        ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_WF_START,
        CMD_WF_WAIT,
        CMD_MAC,
        CMD_E_START,
        CMD_E_WAIT,
        CMD_MUL_EE,
        CMD_MUL_XE,
        CMD_C_START,
        CMD_C_WAIT,
        CMD_GAIN_MUL,
        CMD_GAIN,
        CMD_MUL_EG,
        CMD_E2,
        CMD_MUL_ERR,
        CMD_MUL_RATE,
        CMD_D_START,
        CMD_D_WAIT,
        CMD_E3,
        CMD_Y,
        CMD_S_START,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic accept;
    } ctl_t;

    typedef struct packed {
        logic clr_last;
        logic wf_last;
        logic mac_done;
        logic div_done;
        logic corr_pass;
        logic out_free;
    } stat_t;

endpackage

>>> src/wec_div.sv
module wec_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [wec_pkg::DIV_NW-1:0] num,
    input  logic [wec_pkg::DIV_DW-1:0] den,
    output logic                       done,
    output logic [wec_pkg::DIV_NW-1:0] quo
);
    import wec_pkg::*;

    logic                run_reg;
    logic                done_reg;
    logic [DIV_CW-1:0]   cnt_reg;
    logic [DIV_DW-1:0]   rem_reg;
    logic [DIV_NW-1:0]   quo_reg;
    logic [DIV_DW-1:0]   den_reg;
    logic [DIV_DW:0]     shifted;
    logic                fits;

    // One restoring step: shift in the next numerator bit and try the subtract
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_NW-1]};
        fits    = (shifted >= {1'b0, den_reg});
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == DIV_CW'(DIV_NW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? DIV_DW'(shifted - {1'b0, den_reg}) : shifted[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> src/wec_datapath.sv
module wec_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  wec_pkg::ctl_t       ctl,
    output wec_pkg::stat_t      stat,
    input  logic [1:0]          op,
    input  logic signed [15:0]  sample,
    input  logic [8:0]          frame_position,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  out_sample
);
    import wec_pkg::*;

    localparam int IW       = ((HAW > 10) ? HAW : 10) + 2;
    localparam int IDX_BASE = HISTORY_LENGTH - FRAME_LENGTH;

    // Storage
    logic signed [15:0] hist_mem [HISTORY_LENGTH];
    logic [W_W-1:0]     wt_mem [TAP_COUNT];

    // Pointers and counters
    logic [HAW-1:0] wp_reg;
    logic [HAW-1:0] clr_cnt_reg;
    logic [HAW-1:0] ra_reg;
    logic [WAW-1:0] jf_reg;
    logic [TCW-1:0] j_reg;
    logic [TCW-1:0] taps_reg;

    // Tap pipeline
    logic               v1_reg;
    logic               v2_reg;
    logic               first1_reg;
    logic signed [15:0] hist_rd_reg;
    logic [W_W-1:0]     wt_rd_reg;
    logic [W_W-1:0]     wadd_reg;
    logic signed [33:0] prod_reg;
    logic signed [DIV_NW-1:0] acc_reg;
    logic [DIV_DW-1:0]  wsum_reg;

    // Post-processing registers
    logic signed [15:0] x_reg;
    logic signed [15:0] h0_reg;
    logic signed [16:0] e_reg;
    logic signed [16:0] e2_reg;
    logic signed [16:0] e3_reg;
    logic [30:0]        ee_reg;
    logic [30:0]        p_reg;
    logic [15:0]        c_reg;
    logic [29:0]        gc_reg;
    logic [14:0]        g_reg;
    logic signed [32:0] eg_reg;
    logic signed [33:0] t1_reg;
    logic signed [47:0] t2_reg;
    logic signed [48:0] delta_reg;
    logic signed [17:0] y_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_reg;

    // Combinational helpers
    logic               push_go;
    logic               near_go;
    logic               issue;
    logic signed [IW-1:0] pos_c;
    logic signed [IW-1:0] idx_raw;
    logic [HAW-1:0]     idx_c;
    logic [HAW:0]       idx1;
    logic [HAW:0]       addr_sum;
    logic [HAW-1:0]     addr_c;
    logic [TCW-1:0]     taps_c;
    logic [WDW-1:0]     wf_d;
    logic               div_start;
    logic [DIV_NW-1:0]  div_num;
    logic [DIV_DW-1:0]  div_den;
    logic               div_done;
    logic [DIV_NW-1:0]  div_quo;
    logic [DIV_NW-1:0]  acc_mag;
    logic [DIV_NW-1:0]  t2_mag;
    logic [DIV_DW-1:0]  dden;
    logic [16:0]        y_mag;
    logic [16:0]        e3_mag;
    logic [16:0]        e_mag;
    logic [15:0]        x_mag;
    logic signed [33:0] ee_full;
    logic signed [32:0] xe_full;
    logic [31:0]        gc_full;
    logic signed [32:0] eg_full;
    logic [32:0]        eg_mag;
    logic [32:0]        e2_round;
    logic signed [17:0] err;
    logic signed [33:0] t1_full;
    logic signed [48:0] t2_full;
    logic signed [49:0] e3_sum;
    logic [33:0]        y_div_full;
    logic [15:0]        y_div_q;
    logic               supp_pass;
    logic               load_out;

    assign push_go = ctl.accept && (op == OP_PUSH);
    assign near_go = ctl.accept && (op == OP_NEAR);

    // Aligned history index, tap count and first ring address
    always_comb
    begin
        if (int'(frame_position) >= FRAME_LENGTH)
            pos_c = IW'(FRAME_LENGTH - 1);
        else
            pos_c = IW'(frame_position);
        idx_raw = IW'(IDX_BASE) + pos_c;
        if (idx_raw < 0)
            idx_c = '0;
        else if (idx_raw > IW'(HISTORY_LENGTH - 1))
            idx_c = HAW'(HISTORY_LENGTH - 1);
        else
            idx_c = idx_raw[HAW-1:0];
        idx1 = {1'b0, idx_c} + 1'b1;
        if (int'(idx1) > TAP_COUNT)
            taps_c = TCW'(TAP_COUNT);
        else
            taps_c = TCW'(idx1);
        addr_sum = {1'b0, wp_reg} + {1'b0, idx_c};
        if (addr_sum >= HAW1'(HISTORY_LENGTH))
            addr_c = HAW'(addr_sum - HAW1'(HISTORY_LENGTH));
        else
            addr_c = addr_sum[HAW-1:0];
    end

    assign issue = (ctl.cmd == CMD_MAC) && (j_reg != taps_reg);

    // Magnitudes and divisor terms
    always_comb
    begin
        acc_mag = acc_reg[DIV_NW-1] ? DIV_NW'(-acc_reg) : DIV_NW'(acc_reg);
        t2_mag  = t2_reg[47] ? DIV_NW'(-t2_reg) : DIV_NW'(t2_reg);
        dden    = DIV_DW'(ee_reg) + DIV_DW'(EPS_Q30);
        y_mag   = y_reg[17] ? 17'(-y_reg) : 17'(y_reg);
        e3_mag  = e3_reg[16] ? 17'(-e3_reg) : 17'(e3_reg);
        e_mag   = e_reg[16] ? 17'(-e_reg) : 17'(e_reg);
        x_mag   = x_reg[15] ? 16'(-x_reg) : 16'(x_reg);
        wf_d    = WDW'(WEIGHT_D0) + WDW'(jf_reg);
    end

    // Divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (ctl.cmd)
            CMD_WF_START:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'(WEIGHT_NUM) + DIV_NW'(wf_d >> 1);
                div_den   = DIV_DW'(wf_d);
            end
            CMD_E_START:
            begin
                div_start = 1'b1;
                div_num   = acc_mag + DIV_NW'(wsum_reg >> 1);
                div_den   = wsum_reg;
            end
            CMD_C_START:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'({p_reg, 15'd0});
                div_den   = DIV_DW'(p_reg) + DIV_DW'(EPS_Q30);
            end
            CMD_D_START:
            begin
                div_start = 1'b1;
                div_num   = t2_mag + DIV_NW'(dden >> 1);
                div_den   = dden;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    wec_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // History and weight writes
    always_ff @(posedge clk)
    begin
        if (push_go)
            hist_mem[wp_reg] <= sample;
        else if (ctl.cmd == CMD_CLEAR)
            hist_mem[clr_cnt_reg] <= '0;
        if ((ctl.cmd == CMD_WF_WAIT) && div_done)
            wt_mem[jf_reg] <= div_quo[W_W-1:0];
    end

    // Registered memory reads for the tap loop
    always_ff @(posedge clk)
    begin
        hist_rd_reg <= hist_mem[ra_reg];
        wt_rd_reg   <= wt_mem[j_reg[WAW-1:0]];
    end

    // Pointers, sweep counters and tap loop control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            clr_cnt_reg <= '0;
            jf_reg      <= '0;
            j_reg       <= '0;
            taps_reg    <= '0;
            ra_reg      <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end
        else
        begin
            if (push_go)
                wp_reg <= (wp_reg == HAW'(HISTORY_LENGTH - 1)) ? '0 : wp_reg + 1'b1;
            if (ctl.cmd == CMD_CLEAR)
                clr_cnt_reg <= stat.clr_last ? '0 : clr_cnt_reg + 1'b1;
            if ((ctl.cmd == CMD_WF_WAIT) && div_done)
                jf_reg <= stat.wf_last ? '0 : jf_reg + 1'b1;
            if (near_go)
            begin
                j_reg    <= '0;
                taps_reg <= taps_c;
                ra_reg   <= addr_c;
            end
            else if (issue)
            begin
                j_reg  <= j_reg + 1'b1;
                ra_reg <= (ra_reg == '0) ? HAW'(HISTORY_LENGTH - 1) : ra_reg - 1'b1;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    // Multiply-accumulate over the taps
    always_ff @(posedge clk)
    begin
        first1_reg <= (j_reg == '0);
        prod_reg   <= hist_rd_reg * $signed({1'b0, wt_rd_reg});
        wadd_reg   <= wt_rd_reg;
        if (v1_reg && first1_reg)
            h0_reg <= hist_rd_reg;
        if (near_go)
        begin
            acc_reg  <= '0;
            wsum_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg  <= acc_reg + DIV_NW'(prod_reg);
            wsum_reg <= wsum_reg + DIV_DW'(wadd_reg);
        end
    end

    // Products for the gain and correction steps
    always_comb
    begin
        ee_full  = e_reg * e_reg;
        xe_full  = x_reg * e_reg;
        gc_full  = {16'd0, c_reg} * 32'(GSPAN_Q15);
        eg_full  = e_reg * $signed({1'b0, g_reg});
        eg_mag   = eg_reg[32] ? 33'(-eg_reg) : 33'(eg_reg);
        e2_round = (eg_mag + 33'd16384) >> 15;
        err      = x_reg - e2_reg;
        t1_full  = err * h0_reg;
        t2_full  = t1_reg * $signed(15'(RATE_Q15));
        e3_sum   = e2_reg + delta_reg;
    end

    // Rounded divide by five of the residual magnitude
    always_comb
    begin
        y_div_full = 34'(y_mag + 17'(SUPP_DIV / 2)) * 34'(SUPP_RECIP);
        y_div_q    = y_div_full[SUPP_SHIFT +: 16];
    end

    // Gain, correction and suppression steps
    always_ff @(posedge clk)
    begin
        if (near_go)
            x_reg <= sample;
        unique case (ctl.cmd)
            CMD_E_WAIT:
            begin
                if (div_done)
                    e_reg <= acc_reg[DIV_NW-1] ? -$signed({1'b0, div_quo[15:0]})
                                               : $signed({1'b0, div_quo[15:0]});
            end
            CMD_MUL_EE:
            begin
                ee_reg <= ee_full[30:0];
            end
            CMD_MUL_XE:
            begin
                p_reg <= xe_full[32] ? 31'(-xe_full) : 31'(xe_full);
                g_reg <= 15'(GMIN_Q15);
            end
            CMD_C_WAIT:
            begin
                if (div_done)
                    c_reg <= div_quo[15:0];
            end
            CMD_GAIN_MUL:
            begin
                gc_reg <= gc_full[29:0];
            end
            CMD_GAIN:
            begin
                g_reg <= 15'(GMIN_Q15) + 15'((gc_reg + 30'd16384) >> 15);
            end
            CMD_MUL_EG:
            begin
                eg_reg <= eg_full;
            end
            CMD_E2:
            begin
                e2_reg <= eg_reg[32] ? -$signed(e2_round[16:0]) : $signed(e2_round[16:0]);
            end
            CMD_MUL_ERR:
            begin
                t1_reg <= t1_full;
            end
            CMD_MUL_RATE:
            begin
                t2_reg <= t2_full[47:0];
            end
            CMD_D_WAIT:
            begin
                if (div_done)
                    delta_reg <= t2_reg[47] ? -$signed({1'b0, div_quo})
                                            : $signed({1'b0, div_quo});
            end
            CMD_E3:
            begin
                if (e3_sum > 50'sd32768)
                    e3_reg <= 17'sd32768;
                else if (e3_sum < -50'sd32768)
                    e3_reg <= -17'sd32768;
                else
                    e3_reg <= e3_sum[16:0];
            end
            CMD_Y:
            begin
                y_reg <= x_reg - e3_reg;
            end
            CMD_S_START:
            begin
                if (supp_pass)
                    y_reg <= y_reg[17] ? -$signed({2'b0, y_div_q})
                                       : $signed({2'b0, y_div_q});
            end
            default:
            begin
            end
        endcase
    end

    // Output register: hold until taken
    assign load_out = (ctl.cmd == CMD_OUT) && stat.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (y_reg > 18'sd32767)
                out_reg <= 16'sh7fff;
            else if (y_reg < -18'sd32768)
                out_reg <= -16'sh8000;
            else
                out_reg <= y_reg[15:0];
        end
    end

    // Suppression test on the residual and the corrected estimate
    assign supp_pass = (y_mag > 17'(SUPP_Y_MIN)) && (e3_mag > 17'(SUPP_E_MIN))
                       && (({2'b0, y_mag} << 1) < (19'(e3_mag) * 19'd3));

    // Status back to the controller
    always_comb
    begin
        stat.clr_last  = (clr_cnt_reg == HAW'(HISTORY_LENGTH - 1));
        stat.wf_last   = (jf_reg == WAW'(TAP_COUNT - 1));
        stat.mac_done  = (j_reg == taps_reg) && !v1_reg && !v2_reg;
        stat.div_done  = div_done;
        stat.corr_pass = (x_mag >= 16'(CORR_MIN)) && (e_mag >= 17'(CORR_MIN));
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_reg;

endmodule

>>> src/wec_ctrl.sv
module wec_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     op,
    input  wec_pkg::stat_t stat,
    output wec_pkg::ctl_t  ctl
);
    import wec_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   wready_reg;

    // State register and weight-table ready flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            wready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_WF_WAIT) && stat.div_done && stat.wf_last)
                wready_reg <= 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_last)
                    state_next = wready_reg ? ST_IDLE : ST_WF_START;
            end
            ST_WF_START: state_next = ST_WF_WAIT;
            ST_WF_WAIT:
            begin
                if (stat.div_done)
                    state_next = stat.wf_last ? ST_IDLE : ST_WF_START;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op)
                        OP_NEAR:  state_next = ST_MAC;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MAC:
            begin
                if (stat.mac_done)
                    state_next = ST_E_START;
            end
            ST_E_START: state_next = ST_E_WAIT;
            ST_E_WAIT:
            begin
                if (stat.div_done)
                    state_next = ST_MUL_EE;
            end
            ST_MUL_EE: state_next = ST_MUL_XE;
            ST_MUL_XE: state_next = stat.corr_pass ? ST_C_START : ST_MUL_EG;
            ST_C_START: state_next = ST_C_WAIT;
            ST_C_WAIT:
            begin
                if (stat.div_done)
                    state_next = ST_GAIN_MUL;
            end
            ST_GAIN_MUL: state_next = ST_GAIN;
            ST_GAIN:     state_next = ST_MUL_EG;
            ST_MUL_EG:   state_next = ST_E2;
            ST_E2:       state_next = ST_MUL_ERR;
            ST_MUL_ERR:  state_next = ST_MUL_RATE;
            ST_MUL_RATE: state_next = ST_D_START;
            ST_D_START:  state_next = ST_D_WAIT;
            ST_D_WAIT:
            begin
                if (stat.div_done)
                    state_next = ST_E3;
            end
            ST_E3:      state_next = ST_Y;
            ST_Y:       state_next = ST_S_START;
            ST_S_START: state_next = ST_OUT;
            ST_OUT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        ctl.accept = (state_reg == ST_IDLE) && in_valid;
        unique case (state_reg)
            ST_CLEAR:    ctl.cmd = CMD_CLEAR;
            ST_WF_START: ctl.cmd = CMD_WF_START;
            ST_WF_WAIT:  ctl.cmd = CMD_WF_WAIT;
            ST_MAC:      ctl.cmd = CMD_MAC;
            ST_E_START:  ctl.cmd = CMD_E_START;
            ST_E_WAIT:   ctl.cmd = CMD_E_WAIT;
            ST_MUL_EE:   ctl.cmd = CMD_MUL_EE;
            ST_MUL_XE:   ctl.cmd = CMD_MUL_XE;
            ST_C_START:  ctl.cmd = CMD_C_START;
            ST_C_WAIT:   ctl.cmd = CMD_C_WAIT;
            ST_GAIN_MUL: ctl.cmd = CMD_GAIN_MUL;
            ST_GAIN:     ctl.cmd = CMD_GAIN;
            ST_MUL_EG:   ctl.cmd = CMD_MUL_EG;
            ST_E2:       ctl.cmd = CMD_E2;
            ST_MUL_ERR:  ctl.cmd = CMD_MUL_ERR;
            ST_MUL_RATE: ctl.cmd = CMD_MUL_RATE;
            ST_D_START:  ctl.cmd = CMD_D_START;
            ST_D_WAIT:   ctl.cmd = CMD_D_WAIT;
            ST_E3:       ctl.cmd = CMD_E3;
            ST_Y:        ctl.cmd = CMD_Y;
            ST_S_START:  ctl.cmd = CMD_S_START;
            ST_OUT:      ctl.cmd = CMD_OUT;
            default:     ctl.cmd = CMD_NONE;
        endcase
    end

endmodule

>>> src/weighted_echo_estimate_canceller_top.sv
// Echo canceller working on Q1.15 audio words.
// Input channel (in_valid / in_stall): op, sample, frame_position.
//   op push appends a far-end word to a 1920-entry history ring.
//   op clear zeroes the history, one entry per cycle.
//   op near-end gives one out_sample word; other op codes are dropped.
// Output channel (out_valid / out_stall): out_sample, held in an output
//   register until taken, so the next input word can be accepted meanwhile.
// A near-end word raises out_valid when its final step loads the output register,
//   and the input is free again in the same cycle: the 480-tap weighted sum
//   (one history read and one weight read per cycle, with the reads, the product
//   and the sum registered in turn), two passes of the shared bit-serial divider
//   plus a third for the correlation gain when the level test on x and e passes,
//   and a few multiply steps; suppression uses a reciprocal multiply in one step.
// After reset the block stalls its input while a sweep zeroes the history,
//   then the 480-entry tap weight table is built with the same divider
//   (one divider pass per weight).
// If the receiver stalls, a finished word waits in the output register and
//   a following near-end word completes but waits before its final step.
module weighted_echo_estimate_canceller_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [15:0] sample,
    input  logic [8:0]         frame_position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] out_sample
);
    import wec_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    wec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .stat     (stat),
        .ctl      (ctl)
    );

    wec_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .op             (op),
        .sample         (sample),
        .frame_position (frame_position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_sample     (out_sample)
    );

endmodule
